@@ hdl/icymte_pkg.sv @@
// Shared types, character constants and helper functions for the ICY title extractor.
// No dependencies; every other file but icymte_checker imports this package.
package icymte_pkg;

  localparam logic [15:0] BBM_RESET = 16'd8192;

  localparam logic [3:0] KEY_LEN = 4'd12;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    FP_AUDIO = 2'b01,
    FP_META  = 2'b10
  } frame_phase_t;

  typedef enum logic [3:0] {
    VP_SEARCH  = 4'b0001,
    VP_FIRST   = 4'b0010,
    VP_CAPTURE = 4'b0100,
    VP_DONE    = 4'b1000
  } value_phase_t;

  typedef enum logic [4:0] {
    BK_IDLE     = 5'b00001,
    BK_CMP_RD   = 5'b00010,
    BK_CMP_CHK  = 5'b00100,
    BK_EMIT_RD  = 5'b01000,
    BK_EMIT_WR  = 5'b10000
  } back_state_t;

  // Lower-case key text "streamtitle="
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h73;
      4'd1:    ch = 8'h74;
      4'd2:    ch = 8'h72;
      4'd3:    ch = 8'h65;
      4'd4:    ch = 8'h61;
      4'd5:    ch = 8'h6D;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h69;
      4'd8:    ch = 8'h74;
      4'd9:    ch = 8'h6C;
      4'd10:   ch = 8'h65;
      4'd11:   ch = 8'h3D;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

@@ hdl/icymte_front.sv @@
// Front end: frame counter, key search and value capture into the title buffer.
// Depends on icymte_pkg; hands finished titles to icymte_queue.
module icymte_front import icymte_pkg::*; #(
  parameter int TITLE_MAX = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [15:0]                  cfg_data,
  input  logic                         in_valid,
  input  logic [7:0]                   in_byte,
  input  logic                         full,
  input  logic                         wr_slot,
  output logic                         buf_we,
  output logic [$clog2(TITLE_MAX):0]   buf_addr,
  output logic [7:0]                   buf_data,
  output logic                         push,
  output logic [$clog2(TITLE_MAX+1)-1:0] push_len,
  output logic                         push_ovf
);

  localparam int IDX_W = $clog2(TITLE_MAX);
  localparam int LEN_W = $clog2(TITLE_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TITLE_MAX);

  logic [15:0]      bbm;
  frame_phase_t     phase, phase_next;
  logic [15:0]      audio_count, audio_count_next;
  logic [11:0]      meta_remaining, meta_remaining_next;
  logic [3:0]       key_idx, key_idx_next;
  value_phase_t     vphase, vphase_next;
  logic [LEN_W-1:0] new_len, new_len_next;
  logic [LEN_W-1:0] trimmed, trimmed_next;
  logic             ovf, ovf_next;

  logic             accept;
  logic             is_length;
  logic             capture;
  logic             blank;
  logic [7:0]       folded;
  logic [LEN_W-1:0] fin_len;

  assign accept = in_valid && !full;
  assign folded = fold_case(in_byte);
  assign blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

  always_comb begin
    phase_next          = phase;
    audio_count_next    = audio_count;
    meta_remaining_next = meta_remaining;
    key_idx_next        = key_idx;
    vphase_next         = vphase;
    new_len_next        = new_len;
    trimmed_next        = trimmed;
    ovf_next            = ovf;
    is_length           = (phase == FP_AUDIO) && (audio_count >= bbm);
    capture             = 1'b0;
    buf_we              = 1'b0;
    push                = 1'b0;
    fin_len             = '0;

    if (accept) begin
      unique case (phase)
        FP_AUDIO: begin
          if (is_length) begin
            audio_count_next = '0;
            if (in_byte != 8'd0) begin
              phase_next          = FP_META;
              meta_remaining_next = {in_byte, 4'b0000};
              key_idx_next        = '0;
              vphase_next         = VP_SEARCH;
              new_len_next        = '0;
              trimmed_next        = '0;
              ovf_next            = 1'b0;
            end
          end else begin
            audio_count_next = audio_count + 16'd1;
          end
        end
        FP_META: begin
          unique case (vphase)
            VP_SEARCH: begin
              if (folded == key_char(key_idx)) begin
                key_idx_next = key_idx + 4'd1;
                if (key_idx + 4'd1 == KEY_LEN) begin
                  vphase_next = VP_FIRST;
                end
              end else begin
                key_idx_next = (folded == key_char(4'd0)) ? 4'd1 : 4'd0;
              end
            end
            VP_FIRST: begin
              // drop one leading quote
              if (in_byte == CH_SEMI) begin
                vphase_next = VP_DONE;
              end else begin
                capture     = (in_byte != CH_QUOTE);
                vphase_next = VP_CAPTURE;
              end
            end
            VP_CAPTURE: begin
              if (in_byte == CH_QUOTE || in_byte == CH_SEMI) begin
                vphase_next = VP_DONE;
              end else begin
                capture = 1'b1;
              end
            end
            VP_DONE: begin
            end
            default: begin
            end
          endcase

          if (capture) begin
            if (new_len < LEN_MAX) begin
              // leading blanks are dropped, inner blanks kept but not counted as trimmed
              if (!blank || new_len != '0) begin
                buf_we       = 1'b1;
                new_len_next = new_len + LEN_W'(1);
                if (!blank) begin
                  trimmed_next = new_len + LEN_W'(1);
                end
              end
            end else if (!blank) begin
              ovf_next = 1'b1;
            end
          end

          meta_remaining_next = meta_remaining - 12'd1;
          if (meta_remaining == 12'd1) begin
            fin_len          = ovf_next ? LEN_MAX : trimmed_next;
            push             = (fin_len != '0);
            phase_next       = FP_AUDIO;
            audio_count_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign buf_addr = {wr_slot, new_len[IDX_W-1:0]};
  assign buf_data = in_byte;
  assign push_len = fin_len;
  assign push_ovf = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bbm            <= BBM_RESET;
      phase          <= FP_AUDIO;
      audio_count    <= '0;
      meta_remaining <= '0;
      key_idx        <= '0;
      vphase         <= VP_SEARCH;
      new_len        <= '0;
      trimmed        <= '0;
      ovf            <= 1'b0;
    end else begin
      if (cfg_write) begin
        bbm <= cfg_data;
      end
      phase          <= phase_next;
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
      key_idx        <= key_idx_next;
      vphase         <= vphase_next;
      new_len        <= new_len_next;
      trimmed        <= trimmed_next;
      ovf            <= ovf_next;
    end
  end

endmodule

@@ hdl/icymte_queue.sv @@
// Two-entry queue of finished title descriptors, one per title buffer slot.
// Depends on icymte_pkg; sits between icymte_front and icymte_back.
module icymte_queue import icymte_pkg::*; #(
  parameter int TITLE_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [$clog2(TITLE_MAX+1)-1:0] push_len,
  input  logic                           push_ovf,
  input  logic                           pop,
  output logic                           full,
  output logic                           wr_slot,
  output logic                           head_valid,
  output logic                           head_slot,
  output logic [$clog2(TITLE_MAX+1)-1:0] head_len,
  output logic                           head_ovf
);

  localparam int LEN_W = $clog2(TITLE_MAX + 1);

  logic [1:0]       busy, busy_next;
  logic [LEN_W-1:0] len_q [2];
  logic [1:0]       ovf_q;
  logic             wr_ptr;
  logic             rd_ptr;

  assign full       = busy[wr_ptr];
  assign wr_slot    = wr_ptr;
  assign head_valid = busy[rd_ptr];
  assign head_slot  = rd_ptr;
  assign head_len   = len_q[rd_ptr];
  assign head_ovf   = ovf_q[rd_ptr];

  // push and pop always touch different slots
  always_comb begin
    busy_next = busy;
    if (push) begin
      busy_next[wr_ptr] = 1'b1;
    end
    if (pop) begin
      busy_next[rd_ptr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      busy <= busy_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      len_q[wr_ptr] <= push_len;
      ovf_q[wr_ptr] <= push_ovf;
    end
  end

endmodule

@@ hdl/icymte_back.sv @@
// Back end: title buffer memory, previous-title memory, compare and byte emission.
// Depends on icymte_pkg; reads descriptors from icymte_queue.
module icymte_back import icymte_pkg::*; #(
  parameter int TITLE_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           buf_we,
  input  logic [$clog2(TITLE_MAX):0]     buf_addr,
  input  logic [7:0]                     buf_data,
  input  logic                           head_valid,
  input  logic                           head_slot,
  input  logic [$clog2(TITLE_MAX+1)-1:0] head_len,
  input  logic                           head_ovf,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic                           out_trunc
);

  localparam int IDX_W = $clog2(TITLE_MAX);
  localparam int LEN_W = $clog2(TITLE_MAX + 1);

  logic [7:0] new_mem  [2**(IDX_W+1)];
  logic [7:0] prev_mem [TITLE_MAX];
  logic [7:0] new_q;
  logic [7:0] prev_q;

  back_state_t      state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] prev_len, prev_len_next;
  logic             out_free;
  logic             is_end;
  logic             load;

  assign out_free = !out_valid || !out_stall;
  assign is_end   = (LEN_W'(idx) + LEN_W'(1)) == head_len;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      new_mem[buf_addr] <= buf_data;
    end
    new_q  <= new_mem[{head_slot, idx}];
    prev_q <= prev_mem[idx];
    if (load) begin
      prev_mem[idx] <= new_q;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    prev_len_next = prev_len;
    pop           = 1'b0;
    load          = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          idx_next   = '0;
          // a length change already means a new title
          state_next = (head_len == prev_len) ? BK_CMP_RD : BK_EMIT_RD;
        end
      end
      BK_CMP_RD: begin
        state_next = BK_CMP_CHK;
      end
      BK_CMP_CHK: begin
        if (new_q != prev_q) begin
          idx_next   = '0;
          state_next = BK_EMIT_RD;
        end else if (is_end) begin
          pop        = 1'b1;
          state_next = BK_IDLE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = BK_CMP_RD;
        end
      end
      BK_EMIT_RD: begin
        state_next = BK_EMIT_WR;
      end
      BK_EMIT_WR: begin
        if (out_free) begin
          load = 1'b1;
          if (is_end) begin
            pop           = 1'b1;
            prev_len_next = head_len;
            state_next    = BK_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = BK_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      prev_len  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      prev_len <= prev_len_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= new_q;
      out_last  <= is_end;
      out_trunc <= head_ovf;
    end
  end

endmodule

@@ hdl/icy_metadata_title_extractor.sv @@
// ICY stream title extractor: data_byte takes one stream body byte per cycle while
// data_stall is low. The front end parses frames and captures a title into one of two
// title buffers; data_stall rises only while both buffers hold titles that the back end
// has not yet finished, so input runs at one byte per cycle except right after two
// metadata blocks that close in quick succession. The back end compares a title with the
// previous one byte by byte (read, then check), then emits changed titles byte by byte
// (one memory read, one output load), TITLE_MAX bytes at most. Depends on icymte_pkg.
module icy_metadata_title_extractor import icymte_pkg::*; #(
  parameter int TITLE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        title_valid,
  input  logic        title_stall,
  output logic [7:0]  title_byte,
  output logic        title_last,
  output logic        title_truncated
);

  localparam int IDX_W = $clog2(TITLE_MAX);
  localparam int LEN_W = $clog2(TITLE_MAX + 1);

  logic             full;
  logic             wr_slot;
  logic             buf_we;
  logic [IDX_W:0]   buf_addr;
  logic [7:0]       buf_data;
  logic             push;
  logic [LEN_W-1:0] push_len;
  logic             push_ovf;
  logic             pop;
  logic             head_valid;
  logic             head_slot;
  logic [LEN_W-1:0] head_len;
  logic             head_ovf;

  assign data_stall = full;

  icymte_front #(.TITLE_MAX(TITLE_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (data_valid),
    .in_byte  (data_byte),
    .full     (full),
    .wr_slot  (wr_slot),
    .buf_we   (buf_we),
    .buf_addr (buf_addr),
    .buf_data (buf_data),
    .push     (push),
    .push_len (push_len),
    .push_ovf (push_ovf)
  );

  icymte_queue #(.TITLE_MAX(TITLE_MAX)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_len  (push_len),
    .push_ovf  (push_ovf),
    .pop       (pop),
    .full      (full),
    .wr_slot   (wr_slot),
    .head_valid(head_valid),
    .head_slot (head_slot),
    .head_len  (head_len),
    .head_ovf  (head_ovf)
  );

  icymte_back #(.TITLE_MAX(TITLE_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .buf_we    (buf_we),
    .buf_addr  (buf_addr),
    .buf_data  (buf_data),
    .head_valid(head_valid),
    .head_slot (head_slot),
    .head_len  (head_len),
    .head_ovf  (head_ovf),
    .pop       (pop),
    .out_valid (title_valid),
    .out_stall (title_stall),
    .out_byte  (title_byte),
    .out_last  (title_last),
    .out_trunc (title_truncated)
  );

endmodule

@@ hdl/icymte_checker.sv @@
// Port-level checks for the ICY title extractor, attached by bind.
// Depends only on the top level's ports.
module icymte_checker (
  input logic       clk,
  input logic       rst,
  input logic       data_stall,
  input logic       title_valid,
  input logic       title_stall,
  input logic [7:0] title_byte,
  input logic       title_last,
  input logic       title_truncated
);

  // reset empties the output register and both title buffers
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !title_valid && !data_stall)
    else $error("output valid or input stall after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    title_valid && title_stall |=> title_valid && $stable(title_byte) &&
      $stable(title_last) && $stable(title_truncated))
    else $error("stalled title transaction changed");

  // every emitted byte comes from a written buffer entry
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    title_valid |-> !$isunknown({title_byte, title_last, title_truncated}))
    else $error("title transaction with unknown fields");

endmodule

bind icy_metadata_title_extractor icymte_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .data_stall     (data_stall),
  .title_valid    (title_valid),
  .title_stall    (title_stall),
  .title_byte     (title_byte),
  .title_last     (title_last),
  .title_truncated(title_truncated)
);
